@@ src/rc4_pkg.sv @@
`default_nettype none

package rc4_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = 8;
	localparam int KEY_W       = 64;
	localparam int KEY_LEN_W   = 5;
	localparam int KEY_MAX_LEN = 16;
	localparam int KPOS_W      = 4;
	localparam int REG_IDX_W   = 2;

	typedef logic [IDX_W-1:0] byte_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		byte_t data;
		logic  last;
		logic  rekey;
	} res_t;

	function automatic byte_t key_byte(input logic [KEY_W-1:0] lo,
	                                   input logic [KEY_W-1:0] hi,
	                                   input logic [KPOS_W-1:0] pos);
		logic [2*KEY_W-1:0] k;
		k = {hi, lo};
		return k[{pos, 3'b000} +: IDX_W];
	endfunction

	// zero length and lengths above the maximum use the whole key
	function automatic logic [KEY_LEN_W-1:0] eff_len(input logic [KEY_LEN_W-1:0] len);
		logic [KEY_LEN_W-1:0] r;
		r = len;
		if (len == '0 || len > KEY_LEN_W'(KEY_MAX_LEN)) begin
			r = KEY_LEN_W'(KEY_MAX_LEN);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/rc4_if.sv @@
`default_nettype none

interface rc4_in_if import rc4_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  cmd;
	byte_t data_byte;
	logic  last_byte;

	modport source(output valid, cmd, data_byte, last_byte, input ready);
	modport sink(input valid, cmd, data_byte, last_byte, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;
	logic  is_rekey_done;

	modport source(output valid, out_byte, out_last, is_rekey_done, input ready);
	modport sink(input valid, out_byte, out_last, is_rekey_done, output ready);
endinterface

`default_nettype wire

@@ src/rc4_stream_cipher.sv @@
// Crypt word: read S[i], read S[j] and write S[j], write S[i], register result.
// Rekey word: identity fill, then a read, read, write, write swap per entry.
// A word is taken only when the last is through; the table RAM has one read
// and one write port. Reset clears the indices, the key registers (length 16)
// and the output valid flag; the table is undefined until the first rekey.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [KEY_W-1:0]     cfg_data,
	rc4_in_if.sink                    item,
	rc4_out_if.source                 result
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_FILL = 10'b0000000010,
		ST_K_RN = 10'b0000000100,
		ST_K_RA = 10'b0000001000,
		ST_K_WN = 10'b0000010000,
		ST_K_WA = 10'b0000100000,
		ST_C_J  = 10'b0001000000,
		ST_C_K  = 10'b0010000000,
		ST_C_WI = 10'b0100000000,
		ST_EMIT = 10'b1000000000
	} state_t;

	state_t               state_q;
	logic [KEY_W-1:0]     key_lo_q;
	logic [KEY_W-1:0]     key_hi_q;
	logic [KEY_LEN_W-1:0] key_len_q;
	byte_t                i_q, j_q, n_q, acc_q, held_q, si_q, sj_q, k_q, data_q;
	logic [KPOS_W-1:0]    kpos_q;
	logic                 last_q;
	res_t                 res_q;
	res_t                 out_q;
	logic                 out_valid_q;

	logic                 ram_we;
	byte_t                ram_waddr, ram_wdata, ram_raddr, ram_rdata;
	byte_t                acc_nx, ks;
	logic [KPOS_W-1:0]    kpos_nx;
	logic [KEY_LEN_W-1:0] len_eff;
	logic                 fin_valid, out_free;
	res_t                 fin_res;

	rc4_ram #(
		.WIDTH(IDX_W),
		.DEPTH(TABLE_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= KEY_LEN_W'(KEY_MAX_LEN);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_lo_q  <= cfg_data;
				REG_KEY_HIGH: key_hi_q  <= cfg_data;
				REG_KEY_LEN:  key_len_q <= cfg_data[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_eff = eff_len(key_len_q);
	assign acc_nx  = acc_q + ram_rdata + key_byte(key_lo_q, key_hi_q, kpos_q);
	assign kpos_nx = (({1'b0, kpos_q} + KEY_LEN_W'(1)) >= len_eff) ? '0 : kpos_q + KPOS_W'(1);

	// the swap writes are not yet in the RAM when S[k] is read
	assign ks = (k_q == i_q) ? sj_q : (k_q == j_q) ? si_q : ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = n_q;
		ram_wdata = n_q;
		ram_raddr = n_q;
		unique case (state_q)
			ST_IDLE: ram_raddr = i_q + 8'd1;
			ST_FILL: ram_we = 1'b1;
			ST_K_RN: ram_raddr = n_q;
			ST_K_RA: ram_raddr = acc_nx;
			ST_K_WN: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_K_WA: begin
				ram_we    = 1'b1;
				ram_waddr = acc_q;
				ram_wdata = held_q;
			end
			ST_C_J: ram_raddr = j_q + ram_rdata;
			ST_C_K: begin
				ram_raddr = si_q + ram_rdata;
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
			end
			ST_C_WI: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = sj_q;
			end
			ST_EMIT: ;
			default: ;
		endcase
	end

	always_comb begin
		fin_valid     = 1'b0;
		fin_res.data  = data_q ^ ks;
		fin_res.last  = last_q;
		fin_res.rekey = 1'b0;
		if (state_q == ST_C_WI) begin
			fin_valid = 1'b1;
		end else if (state_q == ST_K_WA && n_q == 8'hFF) begin
			fin_valid     = 1'b1;
			fin_res.data  = '0;
			fin_res.rekey = 1'b1;
		end
	end

	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			acc_q   <= '0;
			kpos_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						n_q <= '0;
						if (item.cmd) begin
							i_q     <= i_q + 8'd1;
							state_q <= ST_C_J;
						end else begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						acc_q   <= '0;
						kpos_q  <= '0;
						state_q <= ST_K_RN;
					end
				end
				ST_K_RN: state_q <= ST_K_RA;
				ST_K_RA: begin
					acc_q   <= acc_nx;
					kpos_q  <= kpos_nx;
					state_q <= ST_K_WN;
				end
				ST_K_WN: state_q <= ST_K_WA;
				ST_K_WA: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= out_free ? ST_IDLE : ST_EMIT;
					end else begin
						state_q <= ST_K_RN;
					end
				end
				ST_C_J: begin
					j_q     <= j_q + ram_rdata;
					state_q <= ST_C_K;
				end
				ST_C_K:  state_q <= ST_C_WI;
				ST_C_WI: state_q <= out_free ? ST_IDLE : ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			data_q <= item.data_byte;
			last_q <= item.last_byte;
		end
		if (state_q == ST_K_RA) begin
			held_q <= ram_rdata;
		end
		if (state_q == ST_C_J) begin
			si_q <= ram_rdata;
		end
		if (state_q == ST_C_K) begin
			sj_q <= ram_rdata;
			k_q  <= si_q + ram_rdata;
		end
		if (fin_valid) begin
			res_q <= fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_valid) begin
			out_q <= fin_res;
		end else if (out_free && state_q == ST_EMIT) begin
			out_q <= res_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_byte      = out_q.data;
	assign result.out_last      = out_q.last;
	assign result.is_rekey_done = out_q.rekey;

	a_fill_identity: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> ram_we && ram_wdata == ram_waddr)
		else $error("fill does not write the identity");

	a_rekey_clears_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K_WA && n_q == 8'hFF) |=> (i_q == '0 && j_q == '0))
		else $error("indices not cleared after key schedule");

	a_crypt_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.cmd) |=> state_q == ST_C_J)
		else $error("crypt word did not start");

	a_rekey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.is_rekey_done) |-> result.out_byte == '0)
		else $error("rekey result carries data");

endmodule

`default_nettype wire

@@ src/rc4_ram.sv @@
`default_nettype none

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ test/rc4_stream_cipher_tb.sv @@
`default_nettype none

module rc4_stream_cipher_tb;
	import rc4_pkg::*;

	localparam logic CMD_REKEY = 1'b0;
	localparam logic CMD_CRYPT = 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int TOTAL_WORDS = 950;
	localparam int STALL_LIMIT = 8000;
	localparam int TAIL_CYCLES = 16;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] idx;
		logic [KEY_W-1:0]     val;
		logic                 cmd;
		byte_t                data;
		logic                 last;
		logic                 typed;
		res_t                 want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_data;

	rc4_in_if  in_words();
	rc4_out_if out_words();

	rc4_stream_cipher DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (in_words),
		.result   (out_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cipher state as the block should hold it
	byte_t                perm_sim [TABLE_DEPTH];
	byte_t                ptr_i;
	byte_t                ptr_j;
	logic [KEY_W-1:0]     key_lo_sim;
	logic [KEY_W-1:0]     key_hi_sim;
	logic [KEY_LEN_W-1:0] key_len_sim;

	res_t      pending_words[$];
	plan_row_t plan[$];
	int        mismatches;
	int        words_sent;
	int        quiet_cycles;
	logic      src_idles;
	logic      sink_idles;

	function automatic void schedule_key();
		logic [2*KEY_W-1:0] key;
		int                 len;
		int                 kpos;
		byte_t              acc;
		byte_t              held;
		key = {key_hi_sim, key_lo_sim};
		len = key_len_sim;
		if (len == 0 || len > KEY_MAX_LEN) begin
			len = KEY_MAX_LEN;
		end
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			perm_sim[n] = byte_t'(n);
		end
		acc = '0;
		kpos = 0;
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			held = perm_sim[n];
			acc = acc + held + key[8*kpos +: 8];
			kpos++;
			if (kpos >= len) begin
				kpos = 0;
			end
			perm_sim[n] = perm_sim[acc];
			perm_sim[acc] = held;
		end
		ptr_i = '0;
		ptr_j = '0;
	endfunction

	function automatic res_t cipher_word(logic cmd, byte_t data, logic last);
		res_t  r;
		byte_t si;
		byte_t sj;
		r.last = last;
		if (cmd == CMD_REKEY) begin
			schedule_key();
			r.data = '0;
			r.rekey = 1'b1;
		end else begin
			ptr_i = ptr_i + 8'd1;
			si = perm_sim[ptr_i];
			ptr_j = ptr_j + si;
			sj = perm_sim[ptr_j];
			perm_sim[ptr_j] = si;
			perm_sim[ptr_i] = sj;
			r.data = data ^ perm_sim[byte_t'(si + sj)];
			r.rekey = 1'b0;
		end
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [REG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic plan_row_t word_row(logic cmd, byte_t data, logic last);
		plan_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.cmd = cmd;
		r.data = data;
		r.last = last;
		return r;
	endfunction

	function automatic plan_row_t rekey_row(logic last);
		plan_row_t r;
		r = word_row(CMD_REKEY, 8'h00, last);
		r.typed = 1'b1;
		r.want = '{data: 8'h00, last: last, rekey: 1'b1};
		return r;
	endfunction

	task automatic flag_mismatch(string field, int got, int want);
		$display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
		@(negedge clk);
		in_words.valid = 1'b0;
		while (pending_words.size() != 0) begin
			@(negedge clk);
		end
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_KEY_LOW:  key_lo_sim = val;
			REG_KEY_HIGH: key_hi_sim = val;
			REG_KEY_LEN:  key_len_sim = val[KEY_LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_word(logic cmd, byte_t data, logic last, logic typed, res_t want);
		int   gap;
		res_t model_res;
		gap = src_idles ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_words.valid = 1'b0;
		end
		@(negedge clk);
		in_words.valid = 1'b1;
		in_words.cmd = cmd;
		in_words.data_byte = data;
		in_words.last_byte = last;
		do @(posedge clk); while (!in_words.ready);
		model_res = cipher_word(cmd, data, last);
		pending_words.push_back(typed ? want : model_res);
		words_sent++;
	endtask

	task automatic random_config();
		int pick;
		logic [KEY_LEN_W-1:0] len;
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 2) != 0) begin
			write_reg(REG_KEY_LOW, pick == 0 ? '0 : pick == 1 ? '1 : {$urandom, $urandom});
		end
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 2) != 0) begin
			write_reg(REG_KEY_HIGH, pick == 0 ? '0 : pick == 1 ? '1 : {$urandom, $urandom});
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 6))
				0: len = 5'd1;
				1: len = 5'd16;
				2: len = 5'd0;
				3: len = KEY_LEN_W'($urandom_range(17, 31));
				default: len = KEY_LEN_W'($urandom_range(1, 16));
			endcase
			write_reg(REG_KEY_LEN, KEY_W'(len));
		end
		if ($urandom_range(0, 15) == 0) begin
			write_reg(REG_UNUSED, {$urandom, $urandom});
		end
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_words.valid && out_words.ready) begin
			if (pending_words.size() == 0) begin
				flag_mismatch("unexpected word", out_words.out_byte, 0);
			end else begin
				want = pending_words.pop_front();
				if (out_words.out_byte !== want.data) begin
					flag_mismatch("out_byte", out_words.out_byte, want.data);
				end
				if (out_words.out_last !== want.last) begin
					flag_mismatch("out_last", out_words.out_last, want.last);
				end
				if (out_words.is_rekey_done !== want.rekey) begin
					flag_mismatch("is_rekey_done", out_words.is_rekey_done, want.rekey);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_words.valid && in_words.ready) || (out_words.valid && out_words.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : drain
		int stall;
		out_words.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_idles ? $urandom_range(0, 3) : 0;
			repeat (stall) begin
				@(negedge clk);
				out_words.ready = 1'b0;
			end
			@(negedge clk);
			out_words.ready = 1'b1;
			do @(posedge clk); while (!out_words.valid);
		end
	end

	initial begin : stimulus
		int   msgs;
		int   len;
		logic last;
		in_words.valid = 1'b0;
		in_words.cmd = CMD_REKEY;
		in_words.data_byte = '0;
		in_words.last_byte = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_LOW;
		cfg_data = '0;
		mismatches = 0;
		words_sent = 0;
		quiet_cycles = 0;
		src_idles = 1'b1;
		sink_idles = 1'b1;
		key_lo_sim = '0;
		key_hi_sim = '0;
		key_len_sim = KEY_LEN_W'(KEY_MAX_LEN);
		ptr_i = '0;
		ptr_j = '0;
		foreach (perm_sim[n]) begin
			perm_sim[n] = '0;
		end

		plan = '{
			rekey_row(1'b0),
			word_row(CMD_CRYPT, 8'h00, 1'b0),
			word_row(CMD_CRYPT, 8'hFF, 1'b1),
			cfg_row(REG_KEY_LOW, 64'h0000_0000_0079_654B),
			cfg_row(REG_KEY_LEN, 64'd3),
			rekey_row(1'b1),
			word_row(CMD_CRYPT, 8'h50, 1'b0),
			word_row(CMD_CRYPT, 8'h6C, 1'b0),
			word_row(CMD_CRYPT, 8'h61, 1'b0),
			word_row(CMD_CRYPT, 8'h69, 1'b0),
			word_row(CMD_CRYPT, 8'h6E, 1'b0),
			word_row(CMD_CRYPT, 8'h74, 1'b0),
			word_row(CMD_CRYPT, 8'h65, 1'b0),
			word_row(CMD_CRYPT, 8'h78, 1'b0),
			word_row(CMD_CRYPT, 8'h74, 1'b1),
			cfg_row(REG_KEY_LOW, '1),
			cfg_row(REG_KEY_HIGH, '1),
			cfg_row(REG_KEY_LEN, 64'd1),
			rekey_row(1'b0),
			word_row(CMD_CRYPT, 8'h00, 1'b0),
			word_row(CMD_CRYPT, 8'hFF, 1'b1),
			// zero length falls back to the whole key
			cfg_row(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF),
			cfg_row(REG_KEY_LEN, 64'd0),
			rekey_row(1'b1),
			word_row(CMD_CRYPT, 8'h5A, 1'b1),
			cfg_row(REG_KEY_LEN, 64'd31),
			rekey_row(1'b0),
			word_row(CMD_CRYPT, 8'hA5, 1'b1),
			// unknown index must leave key and cipher state alone
			cfg_row(REG_UNUSED, '1),
			cfg_row(REG_KEY_LEN, 64'd16),
			word_row(CMD_CRYPT, 8'h3C, 1'b1),
			cfg_row(REG_KEY_LOW, 64'h0),
			cfg_row(REG_KEY_LEN, 64'd17),
			rekey_row(1'b1),
			word_row(CMD_CRYPT, 8'hC3, 1'b0)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				write_reg(plan[r].idx, plan[r].val);
			end else begin
				send_word(plan[r].cmd, plan[r].data, plan[r].last, plan[r].typed,
					plan[r].want);
			end
		end

		while (words_sent < TOTAL_WORDS) begin
			src_idles = ($urandom_range(0, 3) != 0);
			sink_idles = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0) begin
				random_config();
			end
			if ($urandom_range(0, 4) != 0) begin
				send_word(CMD_REKEY, byte_t'($urandom), 1'($urandom), 1'b0, '0);
			end
			msgs = $urandom_range(1, 4);
			repeat (msgs) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					last = (k == len - 1);
					if ($urandom_range(0, 15) == 0) begin
						last = 1'($urandom);
					end
					// rekey in the middle of a message
					if ($urandom_range(0, 63) == 0) begin
						send_word(CMD_REKEY, byte_t'($urandom), 1'($urandom), 1'b0, '0);
					end
					send_word(CMD_CRYPT, byte_t'($urandom), last, 1'b0, '0);
				end
			end
		end

		@(negedge clk);
		in_words.valid = 1'b0;
		while (pending_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
src/rc4_pkg.sv
src/rc4_if.sv
src/rc4_ram.sv
src/rc4_stream_cipher.sv
test/rc4_stream_cipher_tb.sv
